// ----- src/mrda_pkg.sv -----
// ----------------------------------------------------------------------------
// mrda_pkg
// Shared widths and constants of the multi-row decimal adder.
// ----------------------------------------------------------------------------
`default_nettype none

package mrda_pkg;

    localparam int MAX_DIGITS_DEF = 64;
    localparam int MAX_ROWS_DEF   = 255;

    localparam int DIGIT_W = 4;
    localparam int CFG_W   = 7;
    localparam int SUM_W   = 12;
    localparam int TOTAL_W = SUM_W + 1;
    localparam int CARRY_W = 8;
    localparam int POS_W   = 6;
    localparam int ROW_W   = 8;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

    // floor(t / 10) == (t * RECIP) >> RECIP_SHIFT for every t below 43690
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP = 16'd52429;
    localparam int PROD_W = TOTAL_W + RECIP_W;
    localparam int QUOT_W = PROD_W - RECIP_SHIFT;

endpackage

`default_nettype wire

// ----- src/mrda_ram.sv -----
// ----------------------------------------------------------------------------
// mrda_ram
// Column sum memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mrda_ram #(
    parameter int DEPTH = mrda_pkg::MAX_DIGITS_DEF,
    parameter int AW    = 6,
    parameter int DW    = mrda_pkg::SUM_W
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/mrda_div10.sv -----
// ----------------------------------------------------------------------------
// mrda_div10
// Splits a column total into a decimal digit and the carry to the next column.
// ----------------------------------------------------------------------------
`default_nettype none

module mrda_div10 (
    input  wire logic [mrda_pkg::TOTAL_W-1:0] total,
    output logic      [mrda_pkg::QUOT_W-1:0]  quot,
    output logic      [mrda_pkg::DIGIT_W-1:0] rem
);

    logic [mrda_pkg::PROD_W-1:0]  prod;
    logic [mrda_pkg::TOTAL_W-1:0] times10;

    always_comb begin
        prod    = mrda_pkg::PROD_W'(total) * mrda_pkg::PROD_W'(mrda_pkg::RECIP);
        quot    = prod[mrda_pkg::PROD_W-1:mrda_pkg::RECIP_SHIFT];
        // q * 10 as two shifts
        times10 = mrda_pkg::TOTAL_W'({quot, 3'b000}) + mrda_pkg::TOTAL_W'({quot, 1'b0});
        rem     = mrda_pkg::DIGIT_W'(total - times10);
    end

endmodule

`default_nettype wire

// ----- src/multi_row_decimal_adder_top.sv -----
// ----------------------------------------------------------------------------
// multi_row_decimal_adder_top
// Adds rows of decimal digits into per-column sums held in a memory, then
// walks the columns from least significant and emits one sum digit each.
// ----------------------------------------------------------------------------
// Loading: one digit per cycle, a read-modify-write of its column sum with
//   forwarding from the write of the cycle before.
// Walk: the input stalls from the final digit until the last column is emitted;
//   the first result passes the drain state, the read register and the output
//   register, then one per cycle while m_tready is high (single memory read port).
// Reset (aresetn low, synchronous): column sums read as zero through per-column
//   valid bits, counters and error cleared, digit count 1; no clearing pass.
`default_nettype none

module multi_row_decimal_adder_top #(
    parameter int MAX_DIGITS = mrda_pkg::MAX_DIGITS_DEF,
    parameter int MAX_ROWS   = mrda_pkg::MAX_ROWS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration: digit_count
    input  wire logic                           cfg_wen,
    input  wire logic [mrda_pkg::CFG_W-1:0]     cfg_wdata,
    // input words
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mrda_pkg::S_TDATA_W-1:0] s_tdata,   // [3:0] digit, [7:4] zero
    input  wire logic                           s_tlast,   // last_digit
    // result words
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [mrda_pkg::M_TDATA_W-1:0] m_tdata,   // [3:0] digit_out,
                                                           // [9:4] position,
                                                           // [17:10] carry_out,
                                                           // [23:18] zero
    output logic                                m_tuser,   // error
    output logic                                m_tlast    // last
);

    localparam int COL_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int NW    = $clog2(MAX_DIGITS + 1) + 1;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_WALK  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [mrda_pkg::CFG_W-1:0] dcount_reg, dcount_next;
    logic [COL_W-1:0]           col_idx_reg, col_idx_next;
    logic [mrda_pkg::ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic                       err_reg, err_next;
    logic [mrda_pkg::CARRY_W-1:0] carry_reg, carry_next;
    logic [MAX_DIGITS-1:0]      valid_reg, valid_next;

    // load pipeline
    logic                         ld_vld_reg, ld_vld_next;
    logic [COL_W-1:0]             ld_col_reg;
    logic [mrda_pkg::DIGIT_W-1:0] ld_digit_reg;
    logic                         wb_vld_reg;
    logic [COL_W-1:0]             wb_col_reg;
    logic [mrda_pkg::SUM_W-1:0]   wb_data_reg;

    // walk
    logic                         walk_iss_reg, walk_iss_next;
    logic [COL_W-1:0]             walk_col_reg, walk_col_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [COL_W-1:0]             rd_col_reg;
    logic                         rd_bit_reg;

    // output register
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [mrda_pkg::DIGIT_W-1:0] out_digit_reg;
    logic [mrda_pkg::POS_W-1:0]   out_pos_reg;
    logic [mrda_pkg::CARRY_W-1:0] out_carry_reg;
    logic                         out_err_reg;
    logic                         out_last_reg;

    logic                         accept, too_many, take, row_end, issue, emit, final_col;
    logic [NW-1:0]                ncols;
    logic [mrda_pkg::DIGIT_W-1:0] in_digit, digit_ok;
    logic [mrda_pkg::SUM_W-1:0]   rdata, base, new_sum, walk_sum;
    logic [mrda_pkg::TOTAL_W-1:0] total;
    logic [mrda_pkg::QUOT_W-1:0]  quot;
    logic [mrda_pkg::DIGIT_W-1:0] rem;
    logic                         ram_re;
    logic [COL_W-1:0]             ram_raddr;

    mrda_ram #(
        .DEPTH (MAX_DIGITS),
        .AW    (COL_W),
        .DW    (mrda_pkg::SUM_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ld_vld_reg),
        .waddr (ld_col_reg),
        .wdata (new_sum),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    mrda_div10 u_div10 (
        .total (total),
        .quot  (quot),
        .rem   (rem)
    );

    always_comb begin
        if (dcount_reg == '0) begin
            ncols = NW'(1);
        end else if (dcount_reg > mrda_pkg::CFG_W'(MAX_DIGITS)) begin
            ncols = NW'(MAX_DIGITS);
        end else begin
            ncols = NW'(dcount_reg);
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign in_digit = s_tdata[mrda_pkg::DIGIT_W-1:0];
    assign too_many = (row_cnt_reg >= mrda_pkg::ROW_W'(MAX_ROWS));
    assign take     = accept && !too_many;
    assign digit_ok = (in_digit > mrda_pkg::MAX_DIGIT) ? '0 : in_digit;
    assign row_end  = (NW'(col_idx_reg) + NW'(1)) >= ncols;

    // read-modify-write, forwarding the write of the previous cycle
    always_comb begin
        if (wb_vld_reg && (wb_col_reg == ld_col_reg)) begin
            base = wb_data_reg;
        end else if (valid_reg[ld_col_reg]) begin
            base = rdata;
        end else begin
            base = '0;
        end
        new_sum = base + mrda_pkg::SUM_W'(ld_digit_reg);
    end

    assign emit      = rd_vld_reg && (!m_tvalid_reg || m_tready);
    assign issue     = (state_reg == ST_WALK) && walk_iss_reg && (!rd_vld_reg || emit);
    assign final_col = (rd_col_reg == '0);
    assign walk_sum  = rd_bit_reg ? rdata : '0;
    assign total     = mrda_pkg::TOTAL_W'(walk_sum) + mrda_pkg::TOTAL_W'(carry_reg);

    assign ram_re    = issue || take;
    assign ram_raddr = (state_reg == ST_WALK) ? walk_col_reg : col_idx_reg;

    always_comb begin
        state_next    = state_reg;
        dcount_next   = cfg_wen ? cfg_wdata : dcount_reg;
        col_idx_next  = col_idx_reg;
        row_cnt_next  = row_cnt_reg;
        err_next      = err_reg;
        carry_next    = carry_reg;
        valid_next    = valid_reg;
        ld_vld_next   = take;
        walk_iss_next = walk_iss_reg;
        walk_col_next = walk_col_reg;
        rd_vld_next   = rd_vld_reg;
        m_tvalid_next = m_tvalid_reg;

        if (ld_vld_reg) begin
            valid_next[ld_col_reg] = 1'b1;
        end

        if (accept) begin
            if (too_many || (in_digit > mrda_pkg::MAX_DIGIT)) begin
                err_next = 1'b1;
            end
            if (take) begin
                if (row_end) begin
                    col_idx_next = '0;
                    row_cnt_next = row_cnt_reg + 1'b1;
                end else begin
                    col_idx_next = col_idx_reg + 1'b1;
                end
            end
        end

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (issue) begin
            rd_vld_next   = 1'b1;
            walk_col_next = walk_col_reg - 1'b1;
            if (walk_col_reg == '0) begin
                walk_iss_next = 1'b0;
            end
        end else if (emit) begin
            rd_vld_next = 1'b0;
        end

        if (emit) begin
            m_tvalid_next = 1'b1;
            carry_next    = quot[mrda_pkg::CARRY_W-1:0];
        end

        case (state_reg)
            ST_LOAD: begin
                if (accept && s_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // the final digit's write lands in this cycle
                state_next    = ST_WALK;
                walk_iss_next = 1'b1;
                walk_col_next = COL_W'(ncols - NW'(1));
                carry_next    = '0;
            end
            ST_WALK: begin
                if (emit && final_col) begin
                    state_next   = ST_LOAD;
                    valid_next   = '0;
                    col_idx_next = '0;
                    row_cnt_next = '0;
                    err_next     = 1'b0;
                    carry_next   = '0;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            dcount_reg   <= mrda_pkg::CFG_W'(1);
            col_idx_reg  <= '0;
            row_cnt_reg  <= '0;
            err_reg      <= 1'b0;
            carry_reg    <= '0;
            valid_reg    <= '0;
            ld_vld_reg   <= 1'b0;
            wb_vld_reg   <= 1'b0;
            walk_iss_reg <= 1'b0;
            walk_col_reg <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dcount_reg   <= dcount_next;
            col_idx_reg  <= col_idx_next;
            row_cnt_reg  <= row_cnt_next;
            err_reg      <= err_next;
            carry_reg    <= carry_next;
            valid_reg    <= valid_next;
            ld_vld_reg   <= ld_vld_next;
            wb_vld_reg   <= ld_vld_reg;
            walk_iss_reg <= walk_iss_next;
            walk_col_reg <= walk_col_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ld_col_reg   <= col_idx_reg;
            ld_digit_reg <= digit_ok;
        end
        if (ld_vld_reg) begin
            wb_col_reg  <= ld_col_reg;
            wb_data_reg <= new_sum;
        end
        if (issue) begin
            rd_col_reg <= walk_col_reg;
            rd_bit_reg <= valid_reg[walk_col_reg];
        end
        if (emit) begin
            out_digit_reg <= rem;
            out_pos_reg   <= mrda_pkg::POS_W'(rd_col_reg);
            out_carry_reg <= final_col ? quot[mrda_pkg::CARRY_W-1:0] : '0;
            out_err_reg   <= err_reg;
            out_last_reg  <= final_col;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {
        (mrda_pkg::M_TDATA_W - mrda_pkg::DIGIT_W - mrda_pkg::POS_W - mrda_pkg::CARRY_W)'(0),
        out_carry_reg, out_pos_reg, out_digit_reg
    };
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;

    // walk read data only exists while walking
    a_rd_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> state_reg == ST_WALK)
        else $error("walk read pending outside walk");

    // a pending column write never overlaps the walk
    a_ld_not_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_vld_reg |-> state_reg != ST_WALK)
        else $error("column write during walk");

    // emitting column zero ends the run and clears the column valid bits and the error
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && final_col |=> state_reg == ST_LOAD && valid_reg == '0 && !err_reg)
        else $error("run state not cleared after final column");

    // every emitted digit is decimal
    a_digit_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid && out_digit_reg <= mrda_pkg::MAX_DIGIT)
        else $error("result digit above nine");

    // the walk never issues a read while input words are accepted
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> !accept)
        else $error("walk read collides with input word");

endmodule

`default_nettype wire
